### rtl/whkt_pkg.sv
// ----------------------------------------------------------------------------
// whkt_pkg: shared types and constants of the heading tracker
// Angle constants, configuration register indexes and the record that the
// gain divider hands back to the core.
// ----------------------------------------------------------------------------
package whkt_pkg;

  // One full turn and one half turn in 1/128 degree.
  localparam logic [15:0] TURN_U = 16'd46080;
  localparam logic signed [17:0] TURN_S = 18'sd46080;
  localparam logic signed [17:0] HALF_S = 18'sd23040;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_INIT_VAR  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SENS_VAR  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOST_FAC = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOOST_THR = 2'd3;

  // Register values after reset.
  localparam logic [31:0] INIT_VAR_RST  = 32'd65536;
  localparam logic [31:0] SENS_VAR_RST  = 32'd65536;
  localparam logic [15:0] BOOST_FAC_RST = 16'd32768;
  localparam logic [14:0] BOOST_THR_RST = 15'd1280;

  typedef logic [15:0] heading_t;
  typedef logic [31:0] variance_t;
  typedef logic [15:0] gain_t;

  // Result of the gain divider.
  typedef struct packed {
    logic  done;
    gain_t gain;
  } whkt_div_res_t;

endpackage

### rtl/whkt_div.sv
// ----------------------------------------------------------------------------
// whkt_div: bit-serial Kalman gain divider
// Computes gain = floor(P * 65536 / (P + R)) one quotient bit per cycle by
// restoring division. A zero denominator gives zero, and a quotient of
// exactly one saturates to 65535.
// ----------------------------------------------------------------------------
module whkt_div
  import whkt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  variance_t     p_in,
  input  variance_t     r_in,
  output whkt_div_res_t res
);

  localparam logic [4:0] DIV_LAST = 5'd16;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [32:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [16:0] q_r, q_nxt;
  logic        zero_r, zero_nxt;

  logic [33:0] cur;
  logic [33:0] trial;
  logic        ge;

  // One restoring step: the first step compares the unshifted remainder.
  always_comb begin
    cur   = (cnt_r == 5'd0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    ge    = (cur >= {1'b0, den_r});
    trial = cur - {1'b0, den_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      den_nxt  = {1'b0, p_in} + {1'b0, r_in};
      rem_nxt  = {1'b0, p_in};
      q_nxt    = 17'd0;
      zero_nxt = (p_in == 32'd0) && (r_in == 32'd0);
    end else if (busy_r) begin
      rem_nxt = ge ? trial[32:0] : cur[32:0];
      q_nxt   = {q_r[15:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    zero_r <= zero_nxt;
  end

  // Saturate the quotient and force zero for an empty denominator.
  always_comb begin
    res.done = done_r;
    if (zero_r) begin
      res.gain = 16'd0;
    end else if (q_r[16]) begin
      res.gain = 16'hFFFF;
    end else begin
      res.gain = q_r[15:0];
    end
  end

endmodule

### rtl/wrapped_heading_kalman_tracker_core.sv
// ----------------------------------------------------------------------------
// wrapped_heading_kalman_tracker_core: scalar Kalman tracker on a heading
// Filters compass headings in 1/128 degree with wrap-around at a full turn.
//
// Usage:
//   Input beats arrive on in_* (in_tdata = measured heading). Each beat gives
//   one output beat on out_* (out_tdata = filtered heading, out_tuser = set
//   when the large-jump correction was applied instead of the Kalman gain).
//   The cfg_* port writes the initial variance, the sensor variance, the
//   boost factor and the boost threshold; writing the initial variance also
//   reloads the running error variance.
// Sequence:
//   One beat is processed at a time. After an input beat is accepted, the
//   core forms the wrapped difference, runs the bit-serial gain divider and
//   then the bit-serial multipliers, and writes the result before the next
//   input beat can be taken.
// Reset and stalls:
//   rst_n (synchronous, active low) restores the register defaults, clears
//   the heading estimate and loads the variance with its initial value.
//   The result sits in an output register; a new input beat is accepted while
//   it waits, and the core only stalls when its next result is ready too.
// ----------------------------------------------------------------------------
module wrapped_heading_kalman_tracker_core
  import whkt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream: tdata[15:0] = measured_heading.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,
  // Output stream: tdata[15:0] = filtered_heading.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,
  // Output flag: tuser[0] = boost_used.
  output logic                  out_tuser,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [4:0]  MUL_LAST  = 5'd16;
  localparam logic [4:0]  ROUND_BIT = 5'd15;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  // Control and state registers.
  logic [2:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  variance_t   init_var_r, init_var_nxt;
  variance_t   sens_var_r, sens_var_nxt;
  logic [15:0] boost_fac_r, boost_fac_nxt;
  logic [14:0] boost_thr_r, boost_thr_nxt;
  heading_t    est_r, est_nxt;
  variance_t   p_r, p_nxt;

  // Payload registers.
  heading_t    meas_r, meas_nxt;
  logic        neg_r, neg_nxt;
  logic [14:0] mag_r, mag_nxt;
  logic        boost_r, boost_nxt;
  logic [16:0] mul_m_r, mul_m_nxt;
  logic [15:0] mul_k_r, mul_k_nxt;
  logic [32:0] acc_p_r, acc_p_nxt;
  logic [16:0] acc_s_r, acc_s_nxt;
  heading_t    out_head_r, out_head_nxt;
  logic        out_boost_r, out_boost_nxt;

  whkt_div_res_t div_res;
  logic          div_start;

  logic signed [17:0] raw, red, wrapd, absd;
  logic [33:0]        p_add;
  logic [17:0]        s_add;
  logic signed [17:0] sum_t, wrap_t;
  logic               out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_head_r;
  assign out_tuser  = out_boost_r;
  assign out_free   = !out_valid_r || out_tready;
  assign div_start  = (state_r == S_DIFF);

  whkt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .p_in  (p_r),
    .r_in  (sens_var_r),
    .res   (div_res)
  );

  // Shortest signed difference, wrapped into a half turn either way.
  always_comb begin
    raw   = $signed({2'b00, meas_r}) - $signed({2'b00, est_r});
    red   = (raw >= TURN_S) ? raw - TURN_S : raw;
    if (red < -HALF_S) begin
      wrapd = red + TURN_S;
    end else if (red > HALF_S) begin
      wrapd = red - TURN_S;
    end else begin
      wrapd = red;
    end
    absd = (wrapd < 18'sd0) ? -wrapd : wrapd;
  end

  // Shift-add steps: variance times (1 - gain), step magnitude times factor.
  always_comb begin
    p_add = {1'b0, acc_p_r} + (mul_m_r[0] ? {2'b00, p_r} : 34'd0);
    s_add = {1'b0, acc_s_r} + (mul_k_r[0] ? {3'b000, mag_r} : 18'd0)
          + ((cnt_r == ROUND_BIT) ? 18'd1 : 18'd0);
  end

  // New estimate, brought back into one turn.
  always_comb begin
    if (neg_r) begin
      sum_t = $signed({2'b00, est_r}) - $signed({2'b00, acc_s_r[15:0]});
    end else begin
      sum_t = $signed({2'b00, est_r}) + $signed({2'b00, acc_s_r[15:0]});
    end
    if (sum_t < 18'sd0) begin
      wrap_t = sum_t + TURN_S;
    end else if (sum_t >= TURN_S) begin
      wrap_t = sum_t - TURN_S;
    end else begin
      wrap_t = sum_t;
    end
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    init_var_nxt  = init_var_r;
    sens_var_nxt  = sens_var_r;
    boost_fac_nxt = boost_fac_r;
    boost_thr_nxt = boost_thr_r;
    est_nxt       = est_r;
    p_nxt         = p_r;
    meas_nxt      = meas_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    boost_nxt     = boost_r;
    mul_m_nxt     = mul_m_r;
    mul_k_nxt     = mul_k_r;
    acc_p_nxt     = acc_p_r;
    acc_s_nxt     = acc_s_r;
    out_head_nxt  = out_head_r;
    out_boost_nxt = out_boost_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          meas_nxt  = in_tdata;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        neg_nxt   = (wrapd < 18'sd0);
        mag_nxt   = absd[14:0];
        boost_nxt = (absd[14:0] > boost_thr_r);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          mul_m_nxt = ONE_Q16 - {1'b0, div_res.gain};
          mul_k_nxt = boost_r ? boost_fac_r : div_res.gain;
          acc_p_nxt = 33'd0;
          acc_s_nxt = 17'd0;
          cnt_nxt   = 5'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mul_m_nxt = mul_m_r >> 1;
        mul_k_nxt = mul_k_r >> 1;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST) begin
          acc_p_nxt = p_add[32:0];
          state_nxt = S_FIN;
        end else begin
          acc_p_nxt = p_add[33:1];
          acc_s_nxt = s_add[17:1];
        end
      end
      S_FIN: begin
        if (out_free) begin
          est_nxt       = wrap_t[15:0];
          p_nxt         = acc_p_r[31:0];
          out_head_nxt  = wrap_t[15:0];
          out_boost_nxt = boost_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register writes; the initial variance also reloads the running one.
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_INIT_VAR: begin
          init_var_nxt = cfg_wdata;
          p_nxt        = cfg_wdata;
        end
        CFG_SENS_VAR:  sens_var_nxt  = cfg_wdata;
        CFG_BOOST_FAC: boost_fac_nxt = cfg_wdata[15:0];
        CFG_BOOST_THR: boost_thr_nxt = cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      init_var_r  <= INIT_VAR_RST;
      sens_var_r  <= SENS_VAR_RST;
      boost_fac_r <= BOOST_FAC_RST;
      boost_thr_r <= BOOST_THR_RST;
      est_r       <= 16'd0;
      p_r         <= INIT_VAR_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      init_var_r  <= init_var_nxt;
      sens_var_r  <= sens_var_nxt;
      boost_fac_r <= boost_fac_nxt;
      boost_thr_r <= boost_thr_nxt;
      est_r       <= est_nxt;
      p_r         <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    meas_r      <= meas_nxt;
    neg_r       <= neg_nxt;
    mag_r       <= mag_nxt;
    boost_r     <= boost_nxt;
    mul_m_r     <= mul_m_nxt;
    mul_k_r     <= mul_k_nxt;
    acc_p_r     <= acc_p_nxt;
    acc_s_r     <= acc_s_nxt;
    out_head_r  <= out_head_nxt;
    out_boost_r <= out_boost_nxt;
  end

  // The estimate never leaves one turn.
  a_est_range: assert property (@(posedge clk) disable iff (!rst_n)
    est_r < TURN_U)
    else $error("heading estimate outside one turn");

  // A delivered heading is always inside one turn.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_head_r < TURN_U))
    else $error("output heading outside one turn");

  // The divider only finishes while the sequencer waits for it.
  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("gain divider finished outside its wait state");

  // The wrapped difference stays within half a turn during the multiply.
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> ({3'b000, mag_r} <= HALF_S))
    else $error("difference magnitude beyond half a turn");

endmodule
